FILE: design/isort_pkg.sv
// isort_pkg: shared types and constants for the insertion sorter.
// No dependencies; used by isort_cell, isort_ctrl and insertion_sorter.
package isort_pkg;

  localparam int DATA_W = 32;

  // What every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  // Controller phases: loading a set, then draining it
  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } ctl_state_t;

  // Broadcast to all cells: the controller's operation and the input key
  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0] key;
  } cell_ctl_t;

endpackage

FILE: design/isort_cell.sv
// isort_cell: one place of the sorted chain, holding a value and a valid bit.
// Depends on isort_pkg.
module isort_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  isort_pkg::cell_ctl_t                ctl,
  input  logic signed [isort_pkg::DATA_W-1:0] left_val,
  input  logic                                left_valid,
  input  logic                                left_ins,
  input  logic signed [isort_pkg::DATA_W-1:0] right_val,
  input  logic                                right_valid,
  output logic signed [isort_pkg::DATA_W-1:0] val,
  output logic                                valid,
  output logic                                ins
);
  import isort_pkg::*;

  // Insertion point at or below this cell: empty, or strictly larger than the key
  assign ins = !valid || (val > ctl.key);

  // Insert: cells above the insertion point take their lower neighbor,
  // the insertion point takes the key. Shift: move one place toward the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_INSERT: begin
          if (left_ins) begin
            val   <= left_val;
            valid <= left_valid;
          end else if (ins) begin
            val   <= ctl.key;
            valid <= 1'b1;
          end
        end
        OP_SHIFT: begin
          val   <= right_val;
          valid <= right_valid;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: design/isort_ctrl.sv
// isort_ctrl: load/drain sequencer and overflow flag for the insertion sorter.
// Depends on isort_pkg.
module isort_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 last,
  input  logic                 full,
  input  logic                 head_valid,
  input  logic                 next_valid,
  input  logic                 out_ready,
  output logic                 in_ready,
  output logic                 out_valid,
  output logic                 final_res,
  output logic                 overflow,
  output isort_pkg::cell_op_t  op
);
  import isort_pkg::*;

  ctl_state_t state, state_next;
  logic       overflowed, overflowed_next;
  logic       in_take, out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_take && last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!head_valid || (out_take && !next_valid)) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    op        = OP_HOLD;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && !full) op = OP_INSERT;
      end
      ST_DRAIN: begin
        out_valid = head_valid;
        if (out_valid && out_ready) op = OP_SHIFT;
      end
      default: begin
      end
    endcase
  end

  assign final_res = !next_valid;
  assign overflow  = overflowed;

  // Dropped request sets the flag; it clears when the set has drained
  always_comb begin
    overflowed_next = overflowed;
    if (state == ST_DRAIN && state_next == ST_LOAD) begin
      overflowed_next = 1'b0;
    end else if (in_take && full) begin
      overflowed_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      overflowed <= 1'b0;
    end else begin
      state      <= state_next;
      overflowed <= overflowed_next;
    end
  end

endmodule

FILE: design/insertion_sorter.sv
// insertion_sorter: top level, a chain of DEPTH sorting cells and a sequencer.
// Depends on isort_pkg, isort_cell and isort_ctrl.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, value, last          | into block
//  out     | out_valid, out_ready, sorted_value,      | out of block
//          | final_res, overflow                      |
//
// Loading: one request per cycle; every cell compares against the new value
// in parallel and the chain shifts up by one place above the insertion point.
// Draining: one result per cycle from the head cell while out_ready is high,
// and no request is taken until the last result is delivered.
// Reset clears the cell valid bits and the sequencer; a stalled result holds.
module insertion_sorter #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [isort_pkg::DATA_W-1:0] value,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [isort_pkg::DATA_W-1:0] sorted_value,
  output logic                                final_res,
  output logic                                overflow
);
  import isort_pkg::*;

  logic signed [DATA_W-1:0] cell_val   [DEPTH];
  logic                     cell_valid [DEPTH];
  logic                     cell_ins   [DEPTH];
  cell_ctl_t                ctl;
  cell_op_t                 op;

  assign ctl.op  = op;
  assign ctl.key = value;

  // Sequencer
  isort_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last       (last),
    .full       (cell_valid[DEPTH-1]),
    .head_valid (cell_valid[0]),
    .next_valid (cell_valid[1]),
    .out_ready  (out_ready),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .final_res  (final_res),
    .overflow   (overflow),
    .op         (op)
  );

  // Cell chain, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] lv, rv;
    logic                     lvalid, lins, rvalid;

    if (i == 0) begin : g_head
      assign lv     = '0;
      assign lvalid = 1'b0;
      assign lins   = 1'b0;
    end else begin : g_mid_l
      assign lv     = cell_val[i-1];
      assign lvalid = cell_valid[i-1];
      assign lins   = cell_ins[i-1];
    end

    if (i == DEPTH-1) begin : g_tail
      assign rv     = '0;
      assign rvalid = 1'b0;
    end else begin : g_mid_r
      assign rv     = cell_val[i+1];
      assign rvalid = cell_valid[i+1];
    end

    isort_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_val    (lv),
      .left_valid  (lvalid),
      .left_ins    (lins),
      .right_val   (rv),
      .right_valid (rvalid),
      .val         (cell_val[i]),
      .valid       (cell_valid[i]),
      .ins         (cell_ins[i])
    );
  end

  assign sorted_value = cell_val[0];

endmodule
